@@ src/sds_pkg.sv @@
// Shared types, command codes and constants of the state dwell supervisor.
package sds_pkg;

    localparam int MAX_STATES_DEF = 16;

    localparam int SIU_W = 5;

    // Command codes on the request channel
    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_START      = 3'd1;
    localparam logic [2:0] CMD_RUN        = 3'd2;
    localparam logic [2:0] CMD_TICK       = 3'd3;
    localparam logic [2:0] CMD_CHANGE     = 3'd4;
    localparam logic [2:0] CMD_FAULT      = 3'd5;
    localparam logic [2:0] CMD_RESET_TIME = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAULT_JUMP = 2'd0;
    localparam logic [1:0] CFG_TIMEOUTS   = 2'd1;
    localparam logic [1:0] CFG_STATES     = 2'd2;

    // Violation codes
    localparam logic [1:0] VIOL_NONE  = 2'd0;
    localparam logic [1:0] VIOL_MAX   = 2'd1;
    localparam logic [1:0] VIOL_MIN   = 2'd2;
    localparam logic [1:0] VIOL_FAULT = 2'd3;

    localparam logic [7:0] FAULT_DATA_MAX = 8'hFF;
    localparam logic [7:0] FAULT_DATA_MIN = 8'h00;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  entry_index;
        logic [7:0]  target_id;
        logic [31:0] min_dwell_ms;
        logic [31:0] max_dwell_ms;
        logic [7:0]  fault_code;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        active_valid;
        logic [7:0]  active_id;
        logic [31:0] dwell_ms;
        logic        run_action;
        logic        left_state;
        logic        entered_state;
        logic [1:0]  violation;
        logic [7:0]  faulted_state_id;
        logic [7:0]  faulted_data;
        logic        faulted_id_in_table;
    } rsp_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] value;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0]       fault_jump_state;
        logic             timeouts_enabled;
        logic [SIU_W-1:0] states_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_START,
        OP_RUN,
        OP_TICK,
        OP_CHANGE,
        OP_FAULT,
        OP_CLEAR_TIME,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  entry_index;
        logic [7:0]  target_id;
        logic [31:0] min_dwell_ms;
        logic [31:0] max_dwell_ms;
        logic [7:0]  fault_code;
    } op_t;

endpackage

@@ src/sds_chan_if.sv @@
// Valid/ready channel carrying one payload beat.
interface sds_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/sds_front.sv @@
// Front stage: accepts request beats and classifies them into operations.
module sds_front #(
    parameter int MAX_STATES = sds_pkg::MAX_STATES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sds_chan_if.sink    req,
    sds_chan_if.source  op_out
);
    import sds_pkg::*;

    logic valid_reg, valid_next;
    op_t  op_reg, op_next;

    function automatic op_t classify(input req_t r);
        op_t o;
        o.entry_index  = r.entry_index;
        o.target_id    = r.target_id;
        o.min_dwell_ms = r.min_dwell_ms;
        o.max_dwell_ms = r.max_dwell_ms;
        o.fault_code   = r.fault_code;
        unique case (r.cmd)
            CMD_LOAD:
            begin
                // Drop loads beyond the table
                if (32'(r.entry_index) < 32'(MAX_STATES))
                begin
                    o.kind = OP_LOAD;
                end
                else
                begin
                    o.kind = OP_NOP;
                end
            end
            CMD_START:      o.kind = OP_START;
            CMD_RUN:        o.kind = OP_RUN;
            CMD_TICK:       o.kind = OP_TICK;
            CMD_CHANGE:     o.kind = OP_CHANGE;
            CMD_FAULT:      o.kind = OP_FAULT;
            CMD_RESET_TIME: o.kind = OP_CLEAR_TIME;
            default:        o.kind = OP_NOP;
        endcase
        return o;
    endfunction

    assign req.ready    = !valid_reg || op_out.ready;
    assign op_out.valid = valid_reg;
    assign op_out.data  = op_reg;

    always_comb
    begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (op_out.ready)
        begin
            valid_next = 1'b0;
        end
        if (req.valid && req.ready)
        begin
            valid_next = 1'b1;
            op_next    = classify(req.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

@@ src/sds_queue.sv @@
// Two-entry queue that decouples the front stage from the back stage.
module sds_queue #(
    parameter type payload_t = logic
) (
    input  logic        clk,
    input  logic        rst_n,
    sds_chan_if.sink    wr,
    sds_chan_if.source  rd
);

    payload_t   slot_q [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign wr.ready = (fill_reg != 2'd2);
    assign rd.valid = (fill_reg != 2'd0);
    assign rd.data  = slot_q[rd_ptr_reg];
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_q[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

@@ src/sds_back.sv @@
// Back stage: executes operations, scans the state table, registers results.
module sds_back #(
    parameter int MAX_STATES = sds_pkg::MAX_STATES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sds_pkg::cfg_t cfg_q,
    sds_chan_if.sink      op_in,
    sds_chan_if.source    rsp
);
    import sds_pkg::*;

    localparam int SLOT_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW_RAW = $clog2(MAX_STATES + 1);
    localparam int CW     = (CW_RAW > SIU_W) ? CW_RAW : SIU_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // State table, undefined until loaded
    logic [7:0]  tbl_id  [MAX_STATES];
    logic [31:0] tbl_min [MAX_STATES];
    logic [31:0] tbl_max [MAX_STATES];
    logic              tbl_we;
    logic [SLOT_W-1:0] tbl_wslot;

    // Active state and its cached entry
    logic              present_reg, present_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        act_id_reg, act_id_next;
    logic [31:0]       act_min_reg, act_min_next;
    logic [31:0]       act_max_reg, act_max_next;
    logic [31:0]       dwell_reg, dwell_next;
    logic [7:0]        fault_id_reg, fault_id_next;
    logic [7:0]        fault_data_reg, fault_data_next;

    // Per-operation scratch
    logic              goto_reg, goto_next;
    logic [7:0]        target_reg, target_next;
    logic              status_reg, status_next;
    logic              run_reg, run_next;
    logic              left_reg, left_next;
    logic [1:0]        viol_reg, viol_next;
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] found_slot_reg, found_slot_next;
    logic [7:0]        found_id_reg, found_id_next;
    logic [31:0]       found_min_reg, found_min_next;
    logic [31:0]       found_max_reg, found_max_next;
    logic              in_table_reg, in_table_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic [CW-1:0] siu_ext;
    logic [CW-1:0] scan_len;
    logic          min_hit, max_hit;
    logic [7:0]    rd_id;
    logic          take_found;
    logic          present_after;
    logic [7:0]    id_after;

    assign siu_ext  = CW'(cfg_q.states_in_use);
    assign scan_len = (siu_ext > CW'(MAX_STATES)) ? CW'(MAX_STATES) : siu_ext;

    assign min_hit = present_reg && cfg_q.timeouts_enabled && (act_min_reg != 32'd0)
                     && (dwell_reg < act_min_reg);
    assign max_hit = cfg_q.timeouts_enabled && (act_max_reg != 32'd0)
                     && (dwell_reg > act_max_reg);

    assign rd_id         = tbl_id[scan_reg];
    assign take_found    = goto_reg && found_reg;
    assign present_after = take_found || present_reg;
    assign id_after      = take_found ? found_id_reg : act_id_reg;
    assign tbl_wslot     = SLOT_W'(op_in.data.entry_index);

    assign op_in.ready = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.data    = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        tbl_we          = 1'b0;
        present_next    = present_reg;
        slot_next       = slot_reg;
        act_id_next     = act_id_reg;
        act_min_next    = act_min_reg;
        act_max_next    = act_max_reg;
        dwell_next      = dwell_reg;
        fault_id_next   = fault_id_reg;
        fault_data_next = fault_data_reg;
        goto_next       = goto_reg;
        target_next     = target_reg;
        status_next     = status_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        viol_next       = viol_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        found_id_next   = found_id_reg;
        found_min_next  = found_min_reg;
        found_max_next  = found_max_reg;
        in_table_next   = in_table_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_in.valid)
                begin
                    status_next   = 1'b0;
                    run_next      = 1'b0;
                    left_next     = 1'b0;
                    viol_next     = VIOL_NONE;
                    goto_next     = 1'b0;
                    target_next   = op_in.data.target_id;
                    found_next    = 1'b0;
                    in_table_next = 1'b0;
                    scan_next     = '0;
                    unique case (op_in.data.kind)
                        OP_LOAD:
                        begin
                            tbl_we = 1'b1;
                            // Keep the cached entry coherent with the table
                            if (tbl_wslot == slot_reg)
                            begin
                                act_id_next  = op_in.data.target_id;
                                act_min_next = op_in.data.min_dwell_ms;
                                act_max_next = op_in.data.max_dwell_ms;
                            end
                        end
                        OP_START:
                        begin
                            if (cfg_q.states_in_use != '0)
                            begin
                                present_next = 1'b0;
                                goto_next    = 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            if (!present_reg)
                            begin
                                status_next = 1'b1;
                            end
                            else if (max_hit)
                            begin
                                fault_id_next = act_id_reg;
                                goto_next     = 1'b1;
                                left_next     = 1'b1;
                                target_next   = cfg_q.fault_jump_state;
                                if (min_hit)
                                begin
                                    fault_data_next = FAULT_DATA_MIN;
                                    viol_next       = VIOL_MIN;
                                end
                                else
                                begin
                                    fault_data_next = FAULT_DATA_MAX;
                                    viol_next       = VIOL_MAX;
                                end
                            end
                            else
                            begin
                                run_next = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            dwell_next = dwell_reg + 32'd1;
                        end
                        OP_CHANGE:
                        begin
                            goto_next = 1'b1;
                            left_next = present_reg;
                            if (min_hit)
                            begin
                                fault_id_next   = act_id_reg;
                                fault_data_next = FAULT_DATA_MIN;
                                viol_next       = VIOL_MIN;
                                target_next     = cfg_q.fault_jump_state;
                            end
                        end
                        OP_FAULT:
                        begin
                            if (!present_reg)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                fault_id_next   = act_id_reg;
                                fault_data_next = op_in.data.fault_code;
                                viol_next       = VIOL_FAULT;
                                left_next       = 1'b1;
                                goto_next       = 1'b1;
                                target_next     = cfg_q.fault_jump_state;
                            end
                        end
                        OP_CLEAR_TIME:
                        begin
                            dwell_next = 32'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = (scan_len == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // One entry per cycle: first match on the target, any match on the fault id
                if (!found_reg && (rd_id == target_reg))
                begin
                    found_next      = 1'b1;
                    found_slot_next = scan_reg;
                    found_id_next   = rd_id;
                    found_min_next  = tbl_min[scan_reg];
                    found_max_next  = tbl_max[scan_reg];
                end
                if (rd_id == fault_id_reg)
                begin
                    in_table_next = 1'b1;
                end
                if (CW'(scan_reg) == scan_len - CW'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    if (take_found)
                    begin
                        present_next = 1'b1;
                        slot_next    = found_slot_reg;
                        act_id_next  = found_id_reg;
                        act_min_next = found_min_reg;
                        act_max_next = found_max_reg;
                    end
                    if (goto_reg && present_after)
                    begin
                        dwell_next = 32'd0;
                    end
                    rsp_next.status              = status_reg;
                    rsp_next.active_valid        = present_after;
                    rsp_next.active_id           = present_after ? id_after : 8'd0;
                    rsp_next.dwell_ms            = (goto_reg && present_after) ? 32'd0
                                                                                : dwell_reg;
                    rsp_next.run_action          = run_reg;
                    rsp_next.left_state          = left_reg;
                    rsp_next.entered_state       = goto_reg && present_after;
                    rsp_next.violation           = viol_reg;
                    rsp_next.faulted_state_id    = fault_id_reg;
                    rsp_next.faulted_data        = fault_data_reg;
                    rsp_next.faulted_id_in_table = in_table_reg;
                    rsp_valid_next               = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            present_reg    <= 1'b0;
            slot_reg       <= '0;
            act_id_reg     <= 8'd0;
            act_min_reg    <= 32'd0;
            act_max_reg    <= 32'd0;
            dwell_reg      <= 32'd0;
            fault_id_reg   <= 8'd0;
            fault_data_reg <= 8'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            slot_reg       <= slot_next;
            act_id_reg     <= act_id_next;
            act_min_reg    <= act_min_next;
            act_max_reg    <= act_max_next;
            dwell_reg      <= dwell_next;
            fault_id_reg   <= fault_id_next;
            fault_data_reg <= fault_data_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goto_reg       <= goto_next;
        target_reg     <= target_next;
        status_reg     <= status_next;
        run_reg        <= run_next;
        left_reg       <= left_next;
        viol_reg       <= viol_next;
        scan_reg       <= scan_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        found_id_reg   <= found_id_next;
        found_min_reg  <= found_min_next;
        found_max_reg  <= found_max_next;
        in_table_reg   <= in_table_next;
        rsp_reg        <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_id[tbl_wslot]  <= op_in.data.target_id;
            tbl_min[tbl_wslot] <= op_in.data.min_dwell_ms;
            tbl_max[tbl_wslot] <= op_in.data.max_dwell_ms;
        end
    end

endmodule

@@ src/state_dwell_supervisor_core.sv @@
// Flow: the back stage takes one operation at a time, scans the table one entry
//   per cycle over n = min(states_in_use, MAX_STATES) entries and emits the result before
//   it takes the next. A two-entry queue lets the front keep accepting meanwhile.
// Reset: asynchronous, active low; clears the active state, dwell counter, fault record
//   and channels, and sets the registers to fault_jump_state 0, timeouts_enabled 1,
//   states_in_use 1. Table entries hold no reset value and need loading before use.
module state_dwell_supervisor_core #(
    parameter int MAX_STATES = sds_pkg::MAX_STATES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    sds_chan_if.sink   req,
    sds_chan_if.source rsp,
    sds_chan_if.sink   cfg
);
    import sds_pkg::*;

    cfg_t cfg_reg, cfg_next;

    sds_chan_if #(.payload_t(op_t)) front_ch ();
    sds_chan_if #(.payload_t(op_t)) back_ch ();

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_FAULT_JUMP: cfg_next.fault_jump_state = cfg.data.value;
                CFG_TIMEOUTS:   cfg_next.timeouts_enabled = cfg.data.value[0];
                CFG_STATES:     cfg_next.states_in_use    = cfg.data.value[SIU_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_jump_state <= 8'd0;
            cfg_reg.timeouts_enabled <= 1'b1;
            cfg_reg.states_in_use    <= SIU_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sds_front #(
        .MAX_STATES (MAX_STATES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .op_out (front_ch)
    );

    sds_queue #(
        .payload_t (op_t)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_ch),
        .rd    (back_ch)
    );

    sds_back #(
        .MAX_STATES (MAX_STATES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg_q (cfg_reg),
        .op_in (back_ch),
        .rsp   (rsp)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the state dwell supervisor: predicted results checked beat by beat.
`timescale 1ns / 100ps

module testbench;
    import sds_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int TABLE_SLOTS = MAX_STATES_DEF;
    localparam int PHASE_ITEMS = 128;
    localparam int MAX_PRINTS = 40;

    logic clk = 1'b0;
    logic rst_n;

    sds_chan_if #(.payload_t(req_t))    req_if ();
    sds_chan_if #(.payload_t(rsp_t))    rsp_if ();
    sds_chan_if #(.payload_t(cfg_wr_t)) cfg_if ();

    state_dwell_supervisor_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicted supervisor state and register copies
    logic [7:0]  tbl_id  [TABLE_SLOTS];
    logic [31:0] tbl_min [TABLE_SLOTS];
    logic [31:0] tbl_max [TABLE_SLOTS];
    bit          act_on;
    int unsigned act_slot;
    logic [31:0] dwell_cnt;
    logic [7:0]  flt_id;
    logic [7:0]  flt_data;
    logic [7:0]  jump_id;
    bit          tmo_en;
    logic [4:0]  siu;
    bit          left_f;
    bit          entered_f;
    logic [1:0]  viol_f;

    rsp_t        expected_rsp [$];
    req_t        cmd_backlog [$];
    logic [7:0]  id_pool [8];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned viol_count [4];
    int unsigned phases_run;
    bit          idle_on;
    int unsigned req_gap;
    int unsigned rsp_stall;

    function automatic int unsigned scan_len();
        return (siu > TABLE_SLOTS) ? TABLE_SLOTS : siu;
    endfunction

    function automatic void log_fault(logic [7:0] data, logic [1:0] kind);
        flt_id = tbl_id[act_slot];
        flt_data = data;
        viol_f = kind;
    endfunction

    function automatic void switch_state(logic [7:0] target, bit check_min);
        logic [7:0]  dest;
        int unsigned n;
        int unsigned i;
        dest = target;
        n = scan_len();
        if (act_on && check_min && tbl_min[act_slot] != 0 && dwell_cnt < tbl_min[act_slot])
        begin
            log_fault(FAULT_DATA_MIN, VIOL_MIN);
            dest = jump_id;
        end
        if (act_on)
            left_f = 1'b1;
        // first match wins; no match keeps the current state
        for (i = 0; i < n; i++)
        begin
            if (tbl_id[i] == dest)
            begin
                act_slot = i;
                act_on = 1'b1;
                break;
            end
        end
        if (act_on)
        begin
            entered_f = 1'b1;
            dwell_cnt = '0;
        end
    endfunction

    function automatic rsp_t next_supervisor_result(req_t r);
        rsp_t        res;
        int unsigned n;
        int unsigned i;
        res = '0;
        left_f = 1'b0;
        entered_f = 1'b0;
        viol_f = VIOL_NONE;
        case (r.cmd)
            CMD_LOAD:
            begin
                tbl_id[r.entry_index] = r.target_id;
                tbl_min[r.entry_index] = r.min_dwell_ms;
                tbl_max[r.entry_index] = r.max_dwell_ms;
            end
            CMD_START:
            begin
                if (siu != 0)
                begin
                    act_on = 1'b0;
                    switch_state(r.target_id, 1'b0);
                end
            end
            CMD_RUN:
            begin
                if (!act_on)
                    res.status = 1'b1;
                else if (tmo_en && tbl_max[act_slot] != 0 && dwell_cnt > tbl_max[act_slot])
                begin
                    log_fault(FAULT_DATA_MAX, VIOL_MAX);
                    switch_state(jump_id, tmo_en);
                end
                else
                    res.run_action = 1'b1;
            end
            CMD_TICK:
                dwell_cnt = dwell_cnt + 32'd1;
            CMD_CHANGE:
                switch_state(r.target_id, tmo_en);
            CMD_FAULT:
            begin
                if (!act_on)
                    res.status = 1'b1;
                else
                begin
                    log_fault(r.fault_code, VIOL_FAULT);
                    switch_state(jump_id, 1'b0);
                end
            end
            CMD_RESET_TIME:
                dwell_cnt = '0;
            default: ;
        endcase
        n = scan_len();
        for (i = 0; i < n; i++)
        begin
            if (tbl_id[i] == flt_id)
            begin
                res.faulted_id_in_table = 1'b1;
                break;
            end
        end
        res.active_valid = act_on;
        res.active_id = act_on ? tbl_id[act_slot] : 8'h00;
        res.dwell_ms = dwell_cnt;
        res.left_state = left_f;
        res.entered_state = entered_f;
        res.violation = viol_f;
        res.faulted_state_id = flt_id;
        res.faulted_data = flt_data;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_checked, name, got, want));
    endtask

    task automatic compare_result(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            report_mismatch("result beat arrived with nothing outstanding");
            return;
        end
        want = expected_rsp.pop_front();
        results_checked++;
        viol_count[want.violation]++;
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("active_valid", 32'(got.active_valid), 32'(want.active_valid));
        check_field("active_id", 32'(got.active_id), 32'(want.active_id));
        check_field("dwell_ms", got.dwell_ms, want.dwell_ms);
        check_field("run_action", 32'(got.run_action), 32'(want.run_action));
        check_field("left_state", 32'(got.left_state), 32'(want.left_state));
        check_field("entered_state", 32'(got.entered_state), 32'(want.entered_state));
        check_field("violation", 32'(got.violation), 32'(want.violation));
        check_field("faulted_state_id", 32'(got.faulted_state_id),
                    32'(want.faulted_state_id));
        check_field("faulted_data", 32'(got.faulted_data), 32'(want.faulted_data));
        check_field("faulted_id_in_table", 32'(got.faulted_id_in_table),
                    32'(want.faulted_id_in_table));
    endtask

    // Command driver: predict on every accepted beat, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_rsp.push_back(next_supervisor_result(req_if.data));
                items_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (req_gap != 0)
                begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    req_if.data <= cmd_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        req_gap = $urandom_range(1, 4);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                compare_result(rsp_if.data);
            if (rsp_stall != 0)
            begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    rsp_stall = $urandom_range(1, 4);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_if.data <= '{index: idx, value: val};
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_FAULT_JUMP: jump_id = val;
            CFG_TIMEOUTS:   tmo_en = val[0];
            CFG_STATES:     siu = val[4:0];
            default: ;
        endcase
    endtask

    // Hold until every command is out and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || req_if.valid === 1'b1 || expected_rsp.size() != 0);
    endtask

    function automatic req_t make_cmd(logic [2:0] cmd, logic [3:0] idx, logic [7:0] tgt,
                                      logic [31:0] mn, logic [31:0] mx, logic [7:0] code);
        return '{cmd: cmd, entry_index: idx, target_id: tgt, min_dwell_ms: mn,
                 max_dwell_ms: mx, fault_code: code};
    endfunction

    function automatic logic [7:0] pool_id();
        return id_pool[$urandom_range(0, 7)];
    endfunction

    function automatic req_t random_cmd();
        req_t        r;
        int unsigned pick;
        r = make_cmd(CMD_TICK, 4'($urandom), 8'($urandom), $urandom, $urandom,
                     8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            r.cmd = CMD_LOAD;
            if ($urandom_range(0, 4) != 0)
                r.target_id = pool_id();
            if ($urandom_range(0, 5) != 0)
                r.min_dwell_ms = $urandom_range(0, 6);
            if ($urandom_range(0, 5) != 0)
                r.max_dwell_ms = $urandom_range(0, 5);
        end
        else if (pick < 16)
        begin
            r.cmd = CMD_START;
            if ($urandom_range(0, 3) != 0)
                r.target_id = pool_id();
        end
        else if (pick < 38)
            r.cmd = CMD_RUN;
        else if (pick < 68)
            r.cmd = CMD_TICK;
        else if (pick < 83)
        begin
            r.cmd = CMD_CHANGE;
            if ($urandom_range(0, 3) != 0)
                r.target_id = pool_id();
        end
        else if (pick < 91)
            r.cmd = CMD_FAULT;
        else if (pick < 95)
            r.cmd = CMD_RESET_TIME;
        else if (pick == 99)
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    task automatic run_phase(logic [7:0] jump, bit tmo, logic [7:0] states, bit idling);
        req_t r;
        wait_drained();
        write_reg(CFG_FAULT_JUMP, jump);
        write_reg(CFG_TIMEOUTS, {7'd0, tmo});
        write_reg(CFG_STATES, states);
        idle_on = idling;
        phases_run++;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            r = random_cmd();
            cmd_backlog.push_back(r);
            // stretch dwell now and then so the maximum check can fire
            if (r.cmd == CMD_TICK && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(2, 6))
                    cmd_backlog.push_back(r);
        end
        wait_drained();
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rst_n = 1'b0;
        act_on = 1'b0;
        act_slot = 0;
        dwell_cnt = '0;
        flt_id = '0;
        flt_data = '0;
        jump_id = 8'h00;
        tmo_en = 1'b1;
        siu = 5'd1;
        idle_on = 1'b1;
        id_pool = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom)};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed pass under reset registers: only slot 0 is searched, so load it first
        cmd_backlog.push_back(make_cmd(CMD_LOAD, 4'd0, 8'h00, 32'd2, 32'd3, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RUN, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FAULT, 4'd0, 8'h00, '0, '0, 8'hAA));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED, 4'hF, 8'hFF, '1, '1, 8'hFF));
        cmd_backlog.push_back(make_cmd(CMD_START, 4'd0, 8'h55, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_START, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CHANGE, 4'd0, 8'h00, '0, '0, 8'h00));
        repeat (4)
            cmd_backlog.push_back(make_cmd(CMD_TICK, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RUN, 4'd0, 8'h00, '0, '0, 8'h00));
        repeat (3)
            cmd_backlog.push_back(make_cmd(CMD_TICK, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_CHANGE, 4'd0, 8'h77, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RESET_TIME, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FAULT, 4'd0, 8'h00, '0, '0, 8'h5A));
        cmd_backlog.push_back(make_cmd(CMD_RUN, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FAULT, 4'd0, 8'h00, '0, '0, 8'hFF));
        // maximum below minimum: the timeout jump then trips the minimum check too
        cmd_backlog.push_back(make_cmd(CMD_LOAD, 4'd0, 8'h00, 32'hFFFF_FFFF, 32'd1, 8'h00));
        repeat (2)
            cmd_backlog.push_back(make_cmd(CMD_TICK, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RUN, 4'd0, 8'h00, '0, '0, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_LOAD, 4'hF, 8'hFF, 32'd0, 32'hFFFF_FFFF, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FAULT, 4'd0, 8'h00, '0, '0, 8'h00));
        wait_drained();

        // Fill every slot before any wider search can touch it
        for (int s = 0; s < TABLE_SLOTS; s++)
            cmd_backlog.push_back(make_cmd(CMD_LOAD, 4'(s), pool_id(), $urandom_range(0, 5),
                                           $urandom_range(0, 8), 8'h00));

        run_phase(8'h00, 1'b1, 8'd16, 1'b1);
        run_phase(8'hFF, 1'b0, 8'd16, 1'b1);
        run_phase(pool_id(), 1'b1, 8'd1, 1'b0);
        run_phase(8'($urandom), 1'b1, 8'd0, 1'b1);
        run_phase(pool_id(), 1'b1, 8'd31, 1'b1);
        run_phase(pool_id(), 1'($urandom), 8'($urandom_range(1, 16)), 1'b0);

        repeat (24) @(posedge clk);
        $display("summary: %0d commands over %0d register settings, %0d results checked",
                 items_sent, phases_run, results_checked);
        $display("summary: violations seen max %0d, min %0d, commanded %0d",
                 viol_count[VIOL_MAX], viol_count[VIOL_MIN], viol_count[VIOL_FAULT]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
